@@ design/bsrch_pkg.sv @@
// Shared types and codes for the sorted table binary search block.
package bsrch_pkg;

    // Fixed field widths of the streaming and configuration ports.
    localparam int INDEX_W     = 8;
    localparam int KEY_IN_W    = 32;
    localparam int CFG_COUNT_W = 9;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_SIGNED = 2'd1;

    // Input item kinds.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // One search result.
    typedef struct packed {
        logic [INDEX_W-1:0] match_index;
        logic               found;
    } t_result;

endpackage

@@ design/sorted_table_binary_search.sv @@
// Top level of the sorted table binary search block.
//
//  Channel   Direction  Handshake                  Payload
//  s (item)  in         i_s_tvalid / o_s_tready    i_s_tdata, i_s_tuser
//  m (res)   out        o_m_tvalid / i_m_tready    o_m_tdata
//  cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A write beat is stored at the edge that accepts it and gives no result.
// A search with P probes (at most floor(log2(entry_count)) + 1, so 9 for a full
// 256 entry table) runs S_PROBE (table read) then S_WAIT (compare) per probe; a miss
// ends in S_PROBE with an empty window, a hit in S_WAIT, and S_DONE loads the result.
// The input is not ready while a search runs, and a result still waiting to leave
// holds a finished search in its last state.
// Reset (synchronous, active low) clears the sequencer and both configuration
// registers; the table itself is not cleared.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input beat, tdata from bit 0: entry_index[7:0], entry_key[31:0], search_key[31:0].
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [71:0]                         i_s_tdata,
    // Input beat kind, tuser bit 0: action (0 write, 1 search).
    input  logic                                i_s_tuser,
    // Result beat, tdata from bit 0: found, match_index[7:0], then zero fill.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [15:0]                         o_m_tdata,
    // Configuration writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bsrch_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bsrch_pkg::CFG_COUNT_W-1:0]   i_cfg_data
);
    import bsrch_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic [CFG_COUNT_W-1:0] r_entry_count;
    logic                   r_compare_signed;

    logic [INDEX_W-1:0]     in_index;
    logic [KEY_IN_W-1:0]    in_entry_key;
    logic [KEY_IN_W-1:0]    in_search_key;
    logic [KEY_IN_W+KEY_WIDTH-1:0] entry_key_ext;
    logic [KEY_IN_W+KEY_WIDTH-1:0] search_key_ext;

    // Maps every possible write index onto a table slot (index modulo depth).
    logic [ADDR_W-1:0]      slot_map [2**INDEX_W];
    logic [ADDR_W-1:0]      in_slot;

    logic                   tbl_we;
    logic [ADDR_W-1:0]      tbl_waddr;
    logic [KEY_WIDTH-1:0]   tbl_wdata;
    logic                   tbl_re;
    logic [ADDR_W-1:0]      tbl_raddr;
    logic [KEY_WIDTH-1:0]   tbl_rdata;

    t_result                result;

    // Unpack the input beat. Keys are cut or zero extended to KEY_WIDTH bits.
    assign in_index       = i_s_tdata[7:0];
    assign in_entry_key   = i_s_tdata[39:8];
    assign in_search_key  = i_s_tdata[71:40];
    assign entry_key_ext  = {{KEY_WIDTH{1'b0}}, in_entry_key};
    assign search_key_ext = {{KEY_WIDTH{1'b0}}, in_search_key};

    genvar g;
    generate
        for (g = 0; g < 2**INDEX_W; g++) begin : g_slot
            assign slot_map[g] = ADDR_W'(g % TABLE_DEPTH);
        end
    endgenerate

    assign in_slot = slot_map[in_index];

    // Configuration registers take a write in any cycle; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count    <= '0;
            r_compare_signed <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENTRY_COUNT:    r_entry_count    <= i_cfg_data;
                CFG_COMPARE_SIGNED: r_compare_signed <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bsrch_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    bsrch_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_action         (i_s_tuser),
        .i_slot           (in_slot),
        .i_entry_key      (entry_key_ext[KEY_WIDTH-1:0]),
        .i_search_key     (search_key_ext[KEY_WIDTH-1:0]),
        .i_entry_count    (r_entry_count),
        .i_compare_signed (r_compare_signed),
        .o_we             (tbl_we),
        .o_waddr          (tbl_waddr),
        .o_wdata          (tbl_wdata),
        .o_re             (tbl_re),
        .o_raddr          (tbl_raddr),
        .i_rdata          (tbl_rdata),
        .o_res_valid      (o_m_tvalid),
        .i_res_ready      (i_m_tready),
        .o_result         (result)
    );

    assign o_m_tdata = {7'b0, result.match_index, result.found};

endmodule

@@ design/bsrch_table.sv @@
// Key table memory: one write port and one registered read port.
module bsrch_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int ADDR_W      = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  logic [KEY_WIDTH-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_W-1:0]    i_raddr,
    output logic [KEY_WIDTH-1:0] o_rdata
);

    logic [KEY_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bsrch_ctrl.sv @@
// Search sequencer: window registers, the shared key comparator and the result register.
module bsrch_ctrl #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int ADDR_W      = 8,
    parameter int CNT_W       = 9
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_action,
    input  logic [ADDR_W-1:0]                   i_slot,
    input  logic [KEY_WIDTH-1:0]                i_entry_key,
    input  logic [KEY_WIDTH-1:0]                i_search_key,
    input  logic [bsrch_pkg::CFG_COUNT_W-1:0]   i_entry_count,
    input  logic                                i_compare_signed,
    output logic                                o_we,
    output logic [ADDR_W-1:0]                   o_waddr,
    output logic [KEY_WIDTH-1:0]                o_wdata,
    output logic                                o_re,
    output logic [ADDR_W-1:0]                   o_raddr,
    input  logic [KEY_WIDTH-1:0]                i_rdata,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output bsrch_pkg::t_result                  o_result
);
    import bsrch_pkg::*;

    localparam int SAT_W = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_start, n_start;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_probe, n_probe;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic                 r_found, n_found;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic [SAT_W-1:0]     count_ext;
    logic [CNT_W-1:0]     count_sat;
    logic [CNT_W-1:0]     probe_pos;
    logic [KEY_WIDTH-1:0] sign_flip;
    logic [KEY_WIDTH-1:0] key_a;
    logic [KEY_WIDTH-1:0] key_b;
    logic                 key_lt;
    logic                 key_gt;
    logic [ADDR_W+INDEX_W-1:0] probe_wide;
    logic                 accept;

    assign count_ext = SAT_W'(i_entry_count);
    assign count_sat = (count_ext > SAT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(count_ext);

    // The window invariant start + count <= depth keeps every probe in range.
    assign probe_pos = r_start + (r_count >> 1);

    // Signed compare is an unsigned compare with both sign bits flipped.
    assign sign_flip = {KEY_WIDTH{i_compare_signed}} & (KEY_WIDTH'(1) << (KEY_WIDTH - 1));
    assign key_a     = r_key ^ sign_flip;
    assign key_b     = i_rdata ^ sign_flip;
    assign key_lt    = key_a < key_b;
    assign key_gt    = key_a > key_b;

    assign probe_wide = {{INDEX_W{1'b0}}, r_probe[ADDR_W-1:0]};

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    assign o_we    = accept && (i_action == ACT_WRITE);
    assign o_waddr = i_slot;
    assign o_wdata = i_entry_key;
    assign o_re    = (r_state == S_PROBE) && (r_count != '0);
    assign o_raddr = probe_pos[ADDR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_start     = r_start;
        n_count     = r_count;
        n_probe     = r_probe;
        n_key       = r_key;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_SEARCH)) begin
                    n_key   = i_search_key;
                    n_start = '0;
                    n_count = count_sat;
                    n_found = 1'b0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_count == '0) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_probe = probe_pos;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (key_lt) begin
                    n_count = r_count >> 1;
                    n_state = S_PROBE;
                end else if (key_gt) begin
                    n_start = r_probe + CNT_W'(1);
                    n_count = r_count - (r_count >> 1) - CNT_W'(1);
                    n_state = S_PROBE;
                end else begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out.found       = r_found;
                    n_out.match_index = r_found ? probe_wide[INDEX_W-1:0] : '0;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_count <= n_count;
        r_probe <= n_probe;
        r_key   <= n_key;
        r_found <= n_found;
        r_out   <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
